### rtl/core/klr_pkg.sv
package klr_pkg;

	localparam int TIME_W      = 32;
	localparam int COMP_W      = 32;
	localparam int IDX_W       = 16;
	localparam int PERIOD_W    = 21;
	localparam int NCOMP       = 4;
	localparam int COMPONENTS  = 4;
	localparam int MAX_SAMPLES = 64;
	localparam int PERIOD_RST  = 2185;
	localparam int CFG_IDX_W   = 1;
	localparam int N_W         = $clog2(MAX_SAMPLES + 1);
	localparam int K_W         = $clog2(NCOMP);
	localparam int MUL_STEPS   = 32;
	localparam int DIV_STEPS   = 66;
	localparam int STEP_W      = 7;

	typedef logic signed [COMP_W-1:0] comp_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD = 1'b0,
		REG_QUAT   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MD_MUL = 1'b0,
		MD_DIV = 1'b1
	} md_op_t;

	typedef struct packed {
		logic        start;
		md_op_t      op;
		logic [32:0] a;
		logic [31:0] b;
		logic [65:0] dividend;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [65:0] prod;
		logic [34:0] quo;
	} md_rsp_t;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_DOT_GO   = 12'b0000_0000_0010,
		S_DOT_WAIT = 12'b0000_0000_0100,
		S_CNT      = 12'b0000_0000_1000,
		S_CNT_WAIT = 12'b0000_0001_0000,
		S_SMP_GO   = 12'b0000_0010_0000,
		S_SMP_MUL  = 12'b0000_0100_0000,
		S_SMP_DIV  = 12'b0000_1000_0000,
		S_SMP_OUT  = 12'b0001_0000_0000,
		S_SKIP_GO  = 12'b0010_0000_0000,
		S_SKIP_WT  = 12'b0100_0000_0000,
		S_FIN      = 12'b1000_0000_0000
	} state_t;

endpackage

### rtl/core/klr_key_if.sv
interface klr_key_if;
	import klr_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] key_time;
	comp_t             comp_x;
	comp_t             comp_y;
	comp_t             comp_z;
	comp_t             comp_w;
	logic              last_key;

	modport source (output valid, key_time, comp_x, comp_y, comp_z, comp_w, last_key,
		input ready);
	modport sink (input valid, key_time, comp_x, comp_y, comp_z, comp_w, last_key,
		output ready);
endinterface

### rtl/core/klr_smp_if.sv
interface klr_smp_if;
	import klr_pkg::*;

	logic             valid;
	logic             ready;
	comp_t            out_x;
	comp_t            out_y;
	comp_t            out_z;
	comp_t            out_w;
	logic [IDX_W-1:0] sample_index;
	logic             run_end;
	logic             truncated;

	modport source (output valid, out_x, out_y, out_z, out_w, sample_index, run_end,
		truncated, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, sample_index, run_end,
		truncated, output ready);
endinterface

### rtl/core/klr_muldiv.sv
module klr_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  klr_pkg::md_req_t req,
	output klr_pkg::md_rsp_t rsp
);
	import klr_pkg::*;

	logic              busy_q;
	logic              done_q;
	md_op_t            op_q;
	logic [32:0]       a_q;
	logic [65:0]       acc_q;
	logic [32:0]       rem_q;
	logic [34:0]       quo_q;
	logic              ovf_q;
	logic [STEP_W-1:0] step_q;

	logic [34:0] mul_sum;
	logic [33:0] r2;
	logic        ge;
	logic [33:0] r2_sub;
	logic        last_step;

	always_comb begin
		mul_sum   = {1'b0, acc_q[65:32]} + (acc_q[0] ? {2'b00, a_q} : 35'd0);
		r2        = {rem_q, acc_q[65]};
		ge        = r2 >= {1'b0, a_q};
		r2_sub    = r2 - {1'b0, a_q};
		last_step = (op_q == MD_MUL) ? (step_q == STEP_W'(MUL_STEPS - 1))
			: (step_q == STEP_W'(DIV_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				a_q    <= req.a;
				step_q <= '0;
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				acc_q  <= (req.op == MD_MUL) ? {34'd0, req.b} : req.dividend;
			end else if (busy_q) begin
				if (op_q == MD_MUL) begin
					acc_q <= {mul_sum, acc_q[31:1]};
				end else begin
					rem_q <= ge ? r2_sub[32:0] : r2[32:0];
					acc_q <= {acc_q[64:0], 1'b0};
					quo_q <= {quo_q[33:0], ge};
					ovf_q <= ovf_q | quo_q[34];
				end
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.prod = acc_q;
		rsp.quo  = (ovf_q || quo_q > 35'h4_0000_0000) ? 35'h4_0000_0000 : quo_q;
	end
endmodule

### rtl/core/keyframe_lerp_resampler_unit.sv
// Keyframe resampler: turns a track of keyframes into evenly spaced samples.
// keys carries one keyframe per item (time, four Q16.16 components, last mark);
// samples carries the interpolated components, running index, run_end and
// truncated. cfg_we/cfg_index/cfg_data write sample_period (index 0) and
// quat_mode (index 1); the user must write them only while the block is
// idle; the block does not enforce it. keys.ready is high only while the
// sequencer is idle; a key is then worked to the end before the next one is
// taken. A first key of a track is only stored. Otherwise a key runs one
// multiply per component for the quaternion dot product (quat_mode only), a
// divide to count its samples (skipped if none falls in the segment), and a
// multiply and a divide per component of each sample (a 32-step shift-add
// multiply and a 66-step restoring divide in the one shared serial unit; none
// on a zero-length segment), plus a multiply when excess samples are skipped
// and a last step to close the key. A finished sample sits in the output
// register; the next sample's arithmetic proceeds meanwhile and the sequencer
// waits only if that register is still full when the next sample is ready.
// Reset clears the track state, sets sample_period to 2185 and quat_mode to 0.
module keyframe_lerp_resampler_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	klr_key_if.sink                          keys,
	klr_smp_if.source                        samples,
	input  logic                             cfg_we,
	input  logic [klr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [klr_pkg::PERIOD_W-1:0]     cfg_data
);
	import klr_pkg::*;

	state_t              state_q;
	logic [PERIOD_W-1:0] period_q;
	logic                quat_q;

	logic [TIME_W-1:0]   t1_q;
	logic                last_q;
	comp_t               v1_q [NCOMP];
	logic [TIME_W-1:0]   prev_time_q;
	comp_t               prev_q [NCOMP];
	logic [TIME_W:0]     st_q;
	logic [IDX_W-1:0]    cnt_q;
	logic                have_prev_q;
	logic                track_done_q;
	logic                flip_q;
	logic signed [66:0]  dot_q;
	logic [K_W-1:0]      k_q;
	logic [TIME_W:0]     count_q;
	logic                trunc_q;
	logic [N_W-1:0]      j_q;
	logic [N_W-1:0]      n_q;
	comp_t               res_q [NCOMP];

	logic                out_valid_q;
	comp_t               out_q [NCOMP];
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_end_q;
	logic                out_trunc_q;

	md_req_t             md_req_q;
	md_rsp_t             md_rsp;

	klr_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req_q),
		.rsp    (md_rsp)
	);

	logic [32:0]        per_eff;
	logic               key_acc;
	comp_t              key_v [NCOMP];
	comp_t              v0;
	comp_t              v1;
	logic [31:0]        abs_v0;
	logic [31:0]        abs_v1;
	logic signed [33:0] d;
	logic signed [33:0] dn;
	logic signed [32:0] dt;
	logic [33:0]        abs_d;
	logic [33:0]        abs_dn;
	logic [32:0]        abs_dt;
	logic               neg;
	logic signed [36:0] r_sum;
	comp_t              r_sat;
	logic               belongs;
	logic [TIME_W:0]    st_next;
	logic [TIME_W:0]    count_new;
	logic [65:0]        skip_sum;
	logic [TIME_W:0]    remain;
	logic signed [66:0] dot_term;

	always_comb begin
		per_eff  = (period_q == '0) ? 33'd1 : {12'd0, period_q};
		key_acc  = keys.valid && keys.ready;
		key_v[0] = keys.comp_x;
		key_v[1] = keys.comp_y;
		key_v[2] = keys.comp_z;
		key_v[3] = (COMPONENTS > 3) ? keys.comp_w : '0;
		v0       = prev_q[k_q];
		v1       = v1_q[k_q];
		abs_v0   = v0[31] ? 32'(-{v0[31], v0}) : 32'(v0);
		abs_v1   = v1[31] ? 32'(-{v1[31], v1}) : 32'(v1);
		d        = (flip_q ? -34'(v1) : 34'(v1)) - 34'(v0);
		dn       = $signed({1'b0, st_q}) - $signed({2'b00, prev_time_q});
		dt       = $signed({1'b0, t1_q}) - $signed({1'b0, prev_time_q});
		abs_d    = d[33] ? 34'(-d) : 34'(d);
		abs_dn   = dn[33] ? 34'(-dn) : 34'(dn);
		abs_dt   = dt[32] ? 33'(-dt) : 33'(dt);
		neg      = d[33] ^ dn[33] ^ dt[32];
		r_sum    = neg ? (37'(v0) - $signed({2'b00, md_rsp.quo}))
			: (37'(v0) + $signed({2'b00, md_rsp.quo}));
		if (r_sum > 37'sd2147483647)
			r_sat = 32'sh7FFF_FFFF;
		else if (r_sum < -37'sd2147483648)
			r_sat = 32'sh8000_0000;
		else
			r_sat = comp_t'(r_sum[31:0]);
		belongs   = last_q ? (st_q < {1'b0, t1_q}) : (st_q <= {1'b0, t1_q});
		st_next   = ({1'b0, st_q} + {1'b0, per_eff} > 34'h1_0000_0000) ? 33'h1_0000_0000
			: 33'(st_q + per_eff);
		count_new = 33'(md_rsp.quo) + 33'd1;
		remain    = count_q - 33'(MAX_SAMPLES);
		skip_sum  = {33'd0, st_q} + md_rsp.prod;
		dot_term  = (v0[31] ^ v1[31]) ? -$signed({1'b0, md_rsp.prod})
			: $signed({1'b0, md_rsp.prod});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_W'(PERIOD_RST);
			quat_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD: period_q <= cfg_data;
				REG_QUAT:   quat_q   <= cfg_data[0];
				default:    period_q <= period_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			prev_time_q    <= '0;
			st_q           <= '0;
			cnt_q          <= '0;
			have_prev_q    <= 1'b0;
			track_done_q   <= 1'b0;
			out_valid_q    <= 1'b0;
			md_req_q.start <= 1'b0;
			for (int i = 0; i < NCOMP; i++)
				prev_q[i] <= '0;
		end else begin
			md_req_q.start <= 1'b0;
			if (samples.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (key_acc) begin
						t1_q   <= keys.key_time;
						last_q <= keys.last_key;
						for (int i = 0; i < NCOMP; i++)
							v1_q[i] <= key_v[i];
						dot_q  <= '0;
						k_q    <= '0;
						if (track_done_q) begin
							st_q  <= '0;
							cnt_q <= '0;
						end
						if (!have_prev_q || track_done_q) begin
							prev_time_q  <= keys.key_time;
							for (int i = 0; i < NCOMP; i++)
								prev_q[i] <= key_v[i];
							have_prev_q  <= 1'b1;
							track_done_q <= keys.last_key;
						end else begin
							state_q <= quat_q ? S_DOT_GO : S_CNT;
						end
					end
				end
				S_DOT_GO: begin
					md_req_q.start <= 1'b1;
					md_req_q.op    <= MD_MUL;
					md_req_q.a     <= {1'b0, abs_v0};
					md_req_q.b     <= abs_v1;
					state_q        <= S_DOT_WAIT;
				end
				S_DOT_WAIT: begin
					if (md_rsp.done) begin
						dot_q <= dot_q + dot_term;
						if (k_q == K_W'(NCOMP - 1)) begin
							state_q <= S_CNT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_DOT_GO;
						end
					end
				end
				S_CNT: begin
					flip_q <= quat_q && dot_q[66];
					k_q    <= '0;
					j_q    <= '0;
					if (!belongs) begin
						count_q <= '0;
						trunc_q <= 1'b0;
						state_q <= S_FIN;
					end else begin
						md_req_q.start    <= 1'b1;
						md_req_q.op       <= MD_DIV;
						md_req_q.a        <= per_eff;
						md_req_q.dividend <= {34'd0, t1_q - st_q[31:0] - {31'd0, last_q}};
						state_q           <= S_CNT_WAIT;
					end
				end
				S_CNT_WAIT: begin
					if (md_rsp.done) begin
						count_q <= count_new;
						trunc_q <= count_new > 33'(MAX_SAMPLES);
						n_q     <= (count_new > 33'(MAX_SAMPLES)) ? N_W'(MAX_SAMPLES)
							: N_W'(count_new);
						state_q <= S_SMP_GO;
					end
				end
				S_SMP_GO: begin
					if (dt == '0) begin
						res_q[k_q] <= v0;
						if (k_q == K_W'(NCOMP - 1))
							state_q <= S_SMP_OUT;
						else
							k_q <= k_q + 1'b1;
					end else begin
						md_req_q.start <= 1'b1;
						md_req_q.op    <= MD_MUL;
						md_req_q.a     <= abs_d[32:0];
						md_req_q.b     <= abs_dn[31:0];
						state_q        <= S_SMP_MUL;
					end
				end
				S_SMP_MUL: begin
					if (md_rsp.done) begin
						md_req_q.start    <= 1'b1;
						md_req_q.op       <= MD_DIV;
						md_req_q.a        <= abs_dt;
						md_req_q.dividend <= md_rsp.prod + {34'd0, abs_dt[32:1]};
						state_q           <= S_SMP_DIV;
					end
				end
				S_SMP_DIV: begin
					if (md_rsp.done) begin
						res_q[k_q] <= r_sat;
						if (k_q == K_W'(NCOMP - 1)) begin
							state_q <= S_SMP_OUT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_SMP_GO;
						end
					end
				end
				S_SMP_OUT: begin
					if (!out_valid_q || samples.ready) begin
						out_valid_q <= 1'b1;
						for (int i = 0; i < NCOMP; i++)
							out_q[i] <= res_q[i];
						out_idx_q   <= cnt_q;
						out_end_q   <= (j_q == n_q - 1'b1);
						out_trunc_q <= trunc_q;
						cnt_q       <= cnt_q + 1'b1;
						st_q        <= st_next;
						j_q         <= j_q + 1'b1;
						k_q         <= '0;
						if (j_q == n_q - 1'b1)
							state_q <= trunc_q ? S_SKIP_GO : S_FIN;
						else
							state_q <= S_SMP_GO;
					end
				end
				S_SKIP_GO: begin
					md_req_q.start <= 1'b1;
					md_req_q.op    <= MD_MUL;
					md_req_q.a     <= per_eff;
					md_req_q.b     <= remain[31:0];
					state_q        <= S_SKIP_WT;
				end
				S_SKIP_WT: begin
					if (md_rsp.done) begin
						st_q    <= (skip_sum > 66'h1_0000_0000) ? 33'h1_0000_0000
							: skip_sum[32:0];
						cnt_q   <= cnt_q + remain[IDX_W-1:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					prev_time_q  <= t1_q;
					for (int i = 0; i < NCOMP; i++)
						prev_q[i] <= v1_q[i];
					have_prev_q  <= 1'b1;
					track_done_q <= last_q;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign keys.ready           = (state_q == S_IDLE);
	assign samples.valid        = out_valid_q;
	assign samples.out_x        = out_q[0];
	assign samples.out_y        = out_q[1];
	assign samples.out_z        = out_q[2];
	assign samples.out_w        = out_q[3];
	assign samples.sample_index = out_idx_q;
	assign samples.run_end      = out_end_q;
	assign samples.truncated    = out_trunc_q;
endmodule

### test/keyframe_lerp_resampler_unit_tb.sv
`timescale 1ns / 100ps

module keyframe_lerp_resampler_unit_tb;
	import klr_pkg::*;

	localparam longint CYCLE_LIMIT = 150_000_000;
	localparam int     SETTLE      = 600;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		comp_t             x;
		comp_t             y;
		comp_t             z;
		comp_t             w;
		logic              last;
	} key_t;

	typedef struct packed {
		comp_t            x;
		comp_t            y;
		comp_t            z;
		comp_t            w;
		logic [IDX_W-1:0] idx;
		logic             run_end;
		logic             trunc;
	} sample_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PERIOD_W-1:0] cfg_data;

	klr_key_if key_bus ();
	klr_smp_if smp_bus ();

	keyframe_lerp_resampler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.keys      (key_bus),
		.samples   (smp_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	key_t    pending[$];
	sample_t samples_due[$];

	logic [PERIOD_W-1:0] period_cfg;
	bit                  quat_cfg;
	logic [TIME_W-1:0]   prev_stamp;
	comp_t               prev_val[4];
	logic [63:0]         sample_time;
	logic [IDX_W-1:0]    sample_count;
	bit                  have_prev;
	bit                  track_done;

	bit     key_taken;
	int     burst_left;
	int     gap_left;
	int     stall_left;
	int     stall_mode;
	int     mismatches;
	int     keys_seen;
	int     samples_seen;
	int     trunc_seen;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit dot_negative(comp_t a[4], comp_t b[4]);
		logic signed [67:0] acc;
		longint p;
		acc = '0;
		for (int k = 0; k < NCOMP; k++) begin
			p = longint'(a[k]) * longint'(b[k]);
			acc = acc + p;
		end
		return acc < 0;
	endfunction

	function automatic comp_t lerp_comp(comp_t v0, comp_t v1, bit flip, longint dn,
		longint dt);
		longint d;
		longint r;
		logic [67:0] ad;
		logic [67:0] adn;
		logic [67:0] adt;
		logic [67:0] q;
		bit neg;
		if (dt == 0)
			return v0;
		d = (flip ? -longint'(v1) : longint'(v1)) - longint'(v0);
		ad = (d < 0) ? 68'(-d) : 68'(d);
		adn = (dn < 0) ? 68'(-dn) : 68'(dn);
		adt = (dt < 0) ? 68'(-dt) : 68'(dt);
		q = (ad * adn + adt / 2) / adt;
		if (q > (68'd1 << 34))
			q = 68'd1 << 34;
		neg = ((d < 0) != (dn < 0)) != (dt < 0);
		r = longint'(v0) + (neg ? -longint'(q[35:0]) : longint'(q[35:0]));
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return comp_t'(r[31:0]);
	endfunction

	function automatic bit in_segment(logic [63:0] t, logic [TIME_W-1:0] t1, bit last);
		return last ? (t < {32'd0, t1}) : (t <= {32'd0, t1});
	endfunction

	task automatic resample_key(key_t k);
		comp_t v1[4];
		logic [63:0] per;
		logic [63:0] skip;
		bit flip;
		bit trunc;
		longint dt;
		longint dn;
		int n;
		int first;
		sample_t s;
		v1[0] = k.x;
		v1[1] = k.y;
		v1[2] = k.z;
		v1[3] = k.w;
		per = (period_cfg == 0) ? 64'd1 : 64'(period_cfg);
		n = 0;
		trunc = 0;
		first = samples_due.size();
		if (track_done) begin
			sample_time = 0;
			sample_count = 0;
			have_prev = 0;
			track_done = 0;
		end
		if (have_prev) begin
			flip = quat_cfg && dot_negative(prev_val, v1);
			dt = longint'({32'd0, k.stamp}) - longint'({32'd0, prev_stamp});
			while (n < MAX_SAMPLES && in_segment(sample_time, k.stamp, k.last)) begin
				dn = longint'(sample_time) - longint'({32'd0, prev_stamp});
				s.x = lerp_comp(prev_val[0], v1[0], flip, dn, dt);
				s.y = lerp_comp(prev_val[1], v1[1], flip, dn, dt);
				s.z = lerp_comp(prev_val[2], v1[2], flip, dn, dt);
				s.w = lerp_comp(prev_val[3], v1[3], flip, dn, dt);
				s.idx = sample_count;
				s.run_end = 0;
				s.trunc = 0;
				samples_due.insert(samples_due.size(), s);
				sample_count++;
				sample_time = sample_time + per;
				if (sample_time > 64'h1_0000_0000)
					sample_time = 64'h1_0000_0000;
				n++;
			end
			if (in_segment(sample_time, k.stamp, k.last)) begin
				if (k.last)
					skip = ({32'd0, k.stamp} - sample_time - 1) / per + 1;
				else
					skip = ({32'd0, k.stamp} - sample_time) / per + 1;
				trunc = 1;
				sample_time = sample_time + skip * per;
				if (sample_time > 64'h1_0000_0000)
					sample_time = 64'h1_0000_0000;
				sample_count = sample_count + skip[IDX_W-1:0];
			end
			if (n > 0)
				samples_due[first + n - 1].run_end = 1;
			for (int j = first; j < first + n; j++)
				samples_due[j].trunc = trunc;
			if (trunc)
				trunc_seen += n;
		end
		prev_stamp = k.stamp;
		for (int c = 0; c < NCOMP; c++)
			prev_val[c] = v1[c];
		have_prev = 1;
		if (k.last)
			track_done = 1;
	endtask

	always @(posedge clk) begin
		sample_t got;
		sample_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			key_taken <= key_bus.valid && key_bus.ready;
			if (key_bus.valid && key_bus.ready) begin
				resample_key('{key_bus.key_time, key_bus.comp_x, key_bus.comp_y,
					key_bus.comp_z, key_bus.comp_w, key_bus.last_key});
				keys_seen++;
			end
			if (smp_bus.valid && smp_bus.ready) begin
				got = '{smp_bus.out_x, smp_bus.out_y, smp_bus.out_z, smp_bus.out_w,
					smp_bus.sample_index, smp_bus.run_end, smp_bus.truncated};
				samples_seen++;
				if (samples_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected sample: %p", got);
				end else begin
					want = samples_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("sample mismatch: expected %p got %p", want, got);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (key_taken)
			void'(pending.pop_front());
		if (key_bus.valid && !key_taken) begin
		end else if (gap_left > 0) begin
			gap_left--;
			key_bus.valid <= 1'b0;
		end else if (pending.size() > 0 && arst_n) begin
			key_bus.valid <= 1'b1;
			key_bus.key_time <= pending[0].stamp;
			key_bus.comp_x <= pending[0].x;
			key_bus.comp_y <= pending[0].y;
			key_bus.comp_z <= pending[0].z;
			key_bus.comp_w <= pending[0].w;
			key_bus.last_key <= pending[0].last;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 6);
				case ($urandom_range(0, 5))
					0, 1: gap_left = 0;
					2: gap_left = $urandom_range(200, 500);
					default: gap_left = $urandom_range(1, 40);
				endcase
			end
		end else begin
			key_bus.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (cycles % 2048 == 0)
			stall_mode = $urandom_range(0, 2);
		if (stall_left > 0) begin
			stall_left--;
			smp_bus.ready <= 1'b0;
		end else begin
			smp_bus.ready <= 1'b1;
			case (stall_mode)
				1: stall_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
				2: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 700) : 0;
				default: stall_left = 0;
			endcase
		end
	end

	function automatic comp_t pick_comp();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			default: return comp_t'($urandom);
		endcase
	endfunction

	task automatic add_key(logic [TIME_W-1:0] stamp, comp_t x, comp_t y, comp_t z, comp_t w,
		bit last);
		key_t k;
		k = '{stamp, x, y, z, w, last};
		pending.insert(pending.size(), k);
	endtask

	task automatic add_track(int nkeys);
		longint per;
		longint t;
		int r;
		per = (period_cfg == 0) ? 1 : period_cfg;
		if ($urandom_range(0, 49) == 0)
			t = 64'hFFFF_0000 + $urandom_range(0, 65535);
		else
			t = $urandom_range(0, 3 * per);
		for (int i = 0; i < nkeys; i++) begin
			if (i > 0) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					t += $urandom_range(64 * per, 200 * per);
				else if (r < 6)
					t -= $urandom_range(0, 2 * per);
				else if (r < 10)
					t += 0;
				else
					t += $urandom_range(0, 4 * per);
				if (t < 0)
					t = 0;
				if (t > 64'hFFFF_FFFF)
					t = 64'hFFFF_FFFF;
			end
			add_key(t[31:0], pick_comp(), pick_comp(), pick_comp(), pick_comp(),
				i == nkeys - 1);
		end
	endtask

	task automatic add_tracks(int target);
		int start;
		start = pending.size();
		while (pending.size() - start < target)
			add_track(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8));
	endtask

	task automatic drain();
		while (pending.size() != 0 || samples_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [PERIOD_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_PERIOD)
			period_cfg = data;
		else
			quat_cfg = data[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [PERIOD_W-1:0] periods[6];
		bit quats[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PERIOD;
		cfg_data = '0;
		key_bus.valid = 1'b0;
		key_bus.key_time = '0;
		key_bus.comp_x = '0;
		key_bus.comp_y = '0;
		key_bus.comp_z = '0;
		key_bus.comp_w = '0;
		key_bus.last_key = 1'b0;
		smp_bus.ready = 1'b0;
		period_cfg = PERIOD_RST;
		quat_cfg = 0;
		prev_stamp = '0;
		for (int c = 0; c < NCOMP; c++)
			prev_val[c] = '0;
		sample_time = 0;
		sample_count = 0;
		have_prev = 0;
		track_done = 0;
		key_taken = 0;
		burst_left = 0;
		gap_left = 0;
		stall_left = 0;
		stall_mode = 0;
		mismatches = 0;
		keys_seen = 0;
		samples_seen = 0;
		trunc_seen = 0;
		cycles = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_key(32'd5000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 0);
		add_key(32'd12000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd65536, 32'sd0, 0);
		add_key(32'd12000, 32'sd1, -32'sd1, 32'sd0, 32'sh7FFF_FFFF, 0);
		add_key(32'd8000, 32'sd100000, 32'sd0, -32'sd100000, 32'sd3, 0);
		add_key(32'd30000, -32'sd5, 32'sd5, 32'sh8000_0000, 32'sd0, 0);
		add_key(32'd32770, 32'sd7, 32'sd9, 32'sd11, 32'sd13, 1);
		add_key(32'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 0);
		add_key(32'd0, 32'sd65536, -32'sd65536, 32'sd1, 32'sd2, 0);
		add_key(32'd2185, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 1);
		add_key(32'd999, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 1);
		add_key(32'd100, 32'sd10, 32'sd20, 32'sd30, 32'sd40, 0);
		add_key(32'h0100_0000, -32'sd10, -32'sd20, -32'sd30, -32'sd40, 0);
		add_key(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 0);
		add_key(32'hFFFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1);
		add_tracks(40);
		drain();

		periods = '{21'd1, 21'd0, 21'd1048576, 21'h1F_FFFF,
			PERIOD_W'($urandom_range(100, 20000)), PERIOD_W'($urandom_range(1000, 200000))};
		quats = '{0, 1, 1, 0, 1, 0};
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_PERIOD, periods[p]);
			write_reg(REG_QUAT, PERIOD_W'(quats[p]));
			if (p == 2) begin
				add_key(32'd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 0);
				add_key(32'd1048576, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, 0);
				add_key(32'd2097152, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 0);
				add_key(32'd4194304, 32'sd0, -32'sd100, 32'sd50, -32'sd50, 1);
			end
			add_tracks(58);
			drain();
		end

		$display("%0d keys taken, %0d samples checked (%0d from truncated keys),",
			keys_seen, samples_seen, trunc_seen);
		$display("periods from zero to the field maximum, quaternion flip on and off");
		if (mismatches == 0 && samples_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
rtl/core/klr_pkg.sv
rtl/core/klr_key_if.sv
rtl/core/klr_smp_if.sv
rtl/core/klr_muldiv.sv
rtl/core/keyframe_lerp_resampler_unit.sv
test/keyframe_lerp_resampler_unit_tb.sv
